FILE: design/lli_pkg.sv
// Shared widths, types and helpers for the line-line intersection block.
package lli_pkg;

  // Input coordinate width and fraction bits of the result.
  localparam int COORD_W = 16;
  localparam int FRAC_W  = 8;
  localparam int OUT_W   = 32;

  // Derived widths of the determinant arithmetic.
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * COORD_W;
  localparam int U_W    = PROD_W + 1;
  localparam int PD_W   = 2 * DIFF_W;
  localparam int DEN_W  = PD_W + 1;
  localparam int M_W    = U_W + DIFF_W;
  localparam int NUM_W  = M_W + 1;
  localparam int QW     = NUM_W + FRAC_W;
  localparam int RW     = DEN_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]   fix_t;

  // One slot of the divider pipeline: both coordinates share the divisor.
  typedef struct packed {
    logic             vld;
    logic             par;
    logic             negx;
    logic             negy;
    logic [RW-1:0]    rx;
    logic [RW-1:0]    ry;
    logic [QW-1:0]    nqx;
    logic [QW-1:0]    nqy;
    logic [DEN_W-1:0] d;
  } div_t;

  // Result value of -1.0 for parallel lines.
  localparam fix_t MINUS_ONE = -(fix_t'(1) <<< FRAC_W);
  localparam fix_t FIX_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam fix_t FIX_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

  // Apply the sign to a quotient magnitude and clamp; the top bit is the clamp flag.
  function automatic logic [OUT_W:0] clamp_q(input logic neg, input logic [QW-1:0] mag);
    logic [QW-1:0] lim;
    lim = QW'({1'b1, {(OUT_W-1){1'b0}}});
    if (neg) begin
      if (mag > lim) clamp_q = {1'b1, FIX_MIN};
      else clamp_q = {1'b0, OUT_W'(~mag + QW'(1))};
    end else begin
      if (mag >= lim) clamp_q = {1'b1, FIX_MAX};
      else clamp_q = {1'b0, OUT_W'(mag)};
    end
  endfunction

endpackage

FILE: design/lli_if.sv
// Valid/ready channel interfaces for line pairs and intersection results.
interface lli_in_if;
  logic            valid;
  logic            ready;
  lli_pkg::coord_t ax;
  lli_pkg::coord_t ay;
  lli_pkg::coord_t bx;
  lli_pkg::coord_t by_coord;
  lli_pkg::coord_t cx;
  lli_pkg::coord_t cy;
  lli_pkg::coord_t dx;
  lli_pkg::coord_t dy;
  modport source (output valid, ax, ay, bx, by_coord, cx, cy, dx, dy, input ready);
  modport sink (input valid, ax, ay, bx, by_coord, cx, cy, dx, dy, output ready);
endinterface

interface lli_out_if;
  logic          valid;
  logic          ready;
  lli_pkg::fix_t hit_x;
  lli_pkg::fix_t hit_y;
  logic          parallel;
  logic          saturated;
  modport source (output valid, hit_x, hit_y, parallel, saturated, input ready);
  modport sink (input valid, hit_x, hit_y, parallel, saturated, output ready);
endinterface

FILE: design/lli_front.sv
// Four pipeline stages computing the determinant, numerators and divider operands.
module lli_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  lli_pkg::coord_t  ax,
  input  lli_pkg::coord_t  ay,
  input  lli_pkg::coord_t  bx,
  input  lli_pkg::coord_t  by_coord,
  input  lli_pkg::coord_t  cx,
  input  lli_pkg::coord_t  cy,
  input  lli_pkg::coord_t  dx,
  input  lli_pkg::coord_t  dy,
  output lli_pkg::div_t    div_o
);

  logic v1_r, v2_r, v3_r;
  logic signed [lli_pkg::DIFF_W-1:0] dx12_r, dy12_r, dx34_r, dy34_r;
  logic signed [lli_pkg::DIFF_W-1:0] dx12b_r, dy12b_r, dx34b_r, dy34b_r;
  logic signed [lli_pkg::PROD_W-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [lli_pkg::PD_W-1:0]   pd1_r, pd2_r;
  logic signed [lli_pkg::U_W-1:0]    u1_r, u2_r;
  logic signed [lli_pkg::DEN_W-1:0]  den_r;
  logic signed [lli_pkg::M_W-1:0]    m1_r, m2_r, m3_r, m4_r;
  lli_pkg::div_t                     div_r;

  logic signed [lli_pkg::NUM_W-1:0]  nx, ny;
  logic signed [lli_pkg::NUM_W-1:0]  ax_abs, ay_abs;
  logic signed [lli_pkg::DEN_W-1:0]  den_abs;
  lli_pkg::div_t                     div_nxt;

  // Valid bits advance with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage one: point differences and the cross products of each line.
  always_ff @(posedge clk) begin
    if (en) begin
      dx12_r <= lli_pkg::DIFF_W'(ax) - lli_pkg::DIFF_W'(bx);
      dy12_r <= lli_pkg::DIFF_W'(ay) - lli_pkg::DIFF_W'(by_coord);
      dx34_r <= lli_pkg::DIFF_W'(cx) - lli_pkg::DIFF_W'(dx);
      dy34_r <= lli_pkg::DIFF_W'(cy) - lli_pkg::DIFF_W'(dy);
      p1_r   <= lli_pkg::PROD_W'(ax) * lli_pkg::PROD_W'(by_coord);
      p2_r   <= lli_pkg::PROD_W'(ay) * lli_pkg::PROD_W'(bx);
      p3_r   <= lli_pkg::PROD_W'(cx) * lli_pkg::PROD_W'(dy);
      p4_r   <= lli_pkg::PROD_W'(cy) * lli_pkg::PROD_W'(dx);
    end
  end

  // Stage two: determinant products and the line constants u1, u2.
  always_ff @(posedge clk) begin
    if (en) begin
      dx12b_r <= dx12_r;
      dy12b_r <= dy12_r;
      dx34b_r <= dx34_r;
      dy34b_r <= dy34_r;
      pd1_r   <= lli_pkg::PD_W'(dx12_r) * lli_pkg::PD_W'(dy34_r);
      pd2_r   <= lli_pkg::PD_W'(dy12_r) * lli_pkg::PD_W'(dx34_r);
      u1_r    <= lli_pkg::U_W'(p1_r) - lli_pkg::U_W'(p2_r);
      u2_r    <= lli_pkg::U_W'(p3_r) - lli_pkg::U_W'(p4_r);
    end
  end

  // Stage three: denominator and the four numerator products.
  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= lli_pkg::DEN_W'(pd1_r) - lli_pkg::DEN_W'(pd2_r);
      m1_r  <= lli_pkg::M_W'(u1_r) * lli_pkg::M_W'(dx34b_r);
      m2_r  <= lli_pkg::M_W'(dx12b_r) * lli_pkg::M_W'(u2_r);
      m3_r  <= lli_pkg::M_W'(u1_r) * lli_pkg::M_W'(dy34b_r);
      m4_r  <= lli_pkg::M_W'(dy12b_r) * lli_pkg::M_W'(u2_r);
    end
  end

  // Stage four: numerators, signs and magnitudes for the divider.
  always_comb begin
    nx      = lli_pkg::NUM_W'(m1_r) - lli_pkg::NUM_W'(m2_r);
    ny      = lli_pkg::NUM_W'(m3_r) - lli_pkg::NUM_W'(m4_r);
    ax_abs  = nx[lli_pkg::NUM_W-1] ? -nx : nx;
    ay_abs  = ny[lli_pkg::NUM_W-1] ? -ny : ny;
    den_abs = den_r[lli_pkg::DEN_W-1] ? -den_r : den_r;
    div_nxt      = div_r;
    div_nxt.par  = (den_r == '0);
    div_nxt.negx = nx[lli_pkg::NUM_W-1] ^ den_r[lli_pkg::DEN_W-1];
    div_nxt.negy = ny[lli_pkg::NUM_W-1] ^ den_r[lli_pkg::DEN_W-1];
    div_nxt.rx   = '0;
    div_nxt.ry   = '0;
    div_nxt.nqx  = lli_pkg::QW'(unsigned'(ax_abs)) << lli_pkg::FRAC_W;
    div_nxt.nqy  = lli_pkg::QW'(unsigned'(ay_abs)) << lli_pkg::FRAC_W;
    div_nxt.d    = unsigned'(den_abs);
  end

  // Divider operand register; only its valid bit is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.vld <= 1'b0;
    end else if (en) begin
      div_r.vld <= v3_r;
    end
    if (en) begin
      div_r.par  <= div_nxt.par;
      div_r.negx <= div_nxt.negx;
      div_r.negy <= div_nxt.negy;
      div_r.rx   <= div_nxt.rx;
      div_r.ry   <= div_nxt.ry;
      div_r.nqx  <= div_nxt.nqx;
      div_r.nqy  <= div_nxt.nqy;
      div_r.d    <= div_nxt.d;
    end
  end

  assign div_o = div_r;

endmodule

FILE: design/lli_div_stage.sv
// One registered restoring-division step for both coordinates.
module lli_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  lli_pkg::div_t st_i,
  output lli_pkg::div_t st_o
);

  lli_pkg::div_t         st_r, st_nxt;
  logic [lli_pkg::RW-1:0] trx, try_r;
  logic [lli_pkg::RW-1:0] dext;

  // Shift the next dividend bit into each remainder and subtract if it fits.
  always_comb begin
    dext   = lli_pkg::RW'(st_i.d);
    trx    = {st_i.rx[lli_pkg::RW-2:0], st_i.nqx[lli_pkg::QW-1]};
    try_r  = {st_i.ry[lli_pkg::RW-2:0], st_i.nqy[lli_pkg::QW-1]};
    st_nxt = st_i;
    if (trx >= dext) begin
      st_nxt.rx  = trx - dext;
      st_nxt.nqx = {st_i.nqx[lli_pkg::QW-2:0], 1'b1};
    end else begin
      st_nxt.rx  = trx;
      st_nxt.nqx = {st_i.nqx[lli_pkg::QW-2:0], 1'b0};
    end
    if (try_r >= dext) begin
      st_nxt.ry  = try_r - dext;
      st_nxt.nqy = {st_i.nqy[lli_pkg::QW-2:0], 1'b1};
    end else begin
      st_nxt.ry  = try_r;
      st_nxt.nqy = {st_i.nqy[lli_pkg::QW-2:0], 1'b0};
    end
  end

  // Stage register; only its valid bit is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r.vld <= st_nxt.vld;
    end
    if (en) begin
      st_r.par  <= st_nxt.par;
      st_r.negx <= st_nxt.negx;
      st_r.negy <= st_nxt.negy;
      st_r.rx   <= st_nxt.rx;
      st_r.ry   <= st_nxt.ry;
      st_r.nqx  <= st_nxt.nqx;
      st_r.nqy  <= st_nxt.nqy;
      st_r.d    <= st_nxt.d;
    end
  end

  assign st_o = st_r;

endmodule

FILE: design/lli_divider.sv
// Pipelined divider: one quotient bit per stage for both coordinates.
module lli_divider (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  lli_pkg::div_t div_i,
  output lli_pkg::div_t div_o
);

  lli_pkg::div_t chain [lli_pkg::QW+1];

  assign chain[0] = div_i;

  // Chain of division steps, most significant quotient bit first.
  for (genvar i = 0; i < lli_pkg::QW; i++) begin : g_step
    lli_div_stage u_stage (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .st_i (chain[i]),
      .st_o (chain[i+1])
    );
  end

  assign div_o = chain[lli_pkg::QW];

endmodule

FILE: design/line_line_intersection.sv
// Line-line intersection by the determinant formula. Each transfer on in_ch
// carries two lines given by two points each; each transfer on out_ch returns
// their intersection in signed Q24.8, truncated toward zero, clamped to 32 bits
// with saturated set, or -1.0 in both coordinates with parallel set when the
// lines are parallel or coincide. A new line pair can be taken every cycle.
// From input transfer to a result on out_ch, data passes four stages of
// multiply and subtract, 59 restoring-division stages (one quotient bit
// each, set by the 59-bit shifted numerator), and the output register. The
// whole pipeline holds while a result waits on out_ch.
module line_line_intersection (
  input  logic      clk,
  input  logic      rst_n,
  lli_in_if.sink    in_ch,
  lli_out_if.source out_ch
);

  logic          en;
  lli_pkg::div_t front_q, div_q;
  logic [lli_pkg::OUT_W:0] cx_q, cy_q;

  logic          out_valid_r;
  lli_pkg::fix_t hit_x_r, hit_y_r;
  logic          parallel_r, saturated_r;

  // The pipeline moves whenever the output register is free or being drained.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  lli_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_ch.valid),
    .ax      (in_ch.ax),
    .ay      (in_ch.ay),
    .bx      (in_ch.bx),
    .by_coord(in_ch.by_coord),
    .cx      (in_ch.cx),
    .cy      (in_ch.cy),
    .dx      (in_ch.dx),
    .dy      (in_ch.dy),
    .div_o   (front_q)
  );

  lli_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .div_i(front_q),
    .div_o(div_q)
  );

  // Sign and clamp the quotients.
  always_comb begin
    cx_q = lli_pkg::clamp_q(div_q.negx, div_q.nqx);
    cy_q = lli_pkg::clamp_q(div_q.negy, div_q.nqy);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_q.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (div_q.par) begin
        hit_x_r     <= lli_pkg::MINUS_ONE;
        hit_y_r     <= lli_pkg::MINUS_ONE;
        parallel_r  <= 1'b1;
        saturated_r <= 1'b0;
      end else begin
        hit_x_r     <= cx_q[lli_pkg::OUT_W-1:0];
        hit_y_r     <= cy_q[lli_pkg::OUT_W-1:0];
        parallel_r  <= 1'b0;
        saturated_r <= cx_q[lli_pkg::OUT_W] | cy_q[lli_pkg::OUT_W];
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit_x     = hit_x_r;
  assign out_ch.hit_y     = hit_y_r;
  assign out_ch.parallel  = parallel_r;
  assign out_ch.saturated = saturated_r;

endmodule

FILE: design/lli_checker.sv
// Port-level checks of the line-line intersection block, bound to the top level.
module lli_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input lli_pkg::fix_t hit_x,
  input lli_pkg::fix_t hit_y,
  input logic          parallel,
  input logic          saturated
);

  // A result waiting for a transfer stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // Parallel lines give -1.0 in both coordinates and no clamp.
  a_par: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && parallel |->
      hit_x == lli_pkg::MINUS_ONE && hit_y == lli_pkg::MINUS_ONE && !saturated)
    else $error("parallel result malformed");

  // A clamp shows as an extreme value in at least one coordinate.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |->
      hit_x == lli_pkg::FIX_MAX || hit_x == lli_pkg::FIX_MIN ||
      hit_y == lli_pkg::FIX_MAX || hit_y == lli_pkg::FIX_MIN)
    else $error("saturated without a clamped coordinate");

  // Nothing is offered right after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind line_line_intersection lli_checker u_lli_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .hit_x    (out_ch.hit_x),
  .hit_y    (out_ch.hit_y),
  .parallel (out_ch.parallel),
  .saturated(out_ch.saturated)
);
